// ===== sv/ffc_pkg.sv =====
// shared types, constants and the crc byte update of the frame checker
package ffc_pkg;

    localparam int HEADER_BYTES = 18;
    localparam int TAIL_BYTES   = 4;
    localparam int IDX_W        = 14;
    localparam int LEN_W        = 13;
    localparam int SUM_W        = 15;
    localparam int CFG_IDX_W    = 1;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [7:0] SYNC_FIRST  = 8'h52;
    localparam logic [7:0] SYNC_SECOND = 8'h47;
    localparam logic [7:0] KIND_SHORT  = 8'd1;
    localparam logic [7:0] KIND_LONG   = 8'd2;

    localparam logic [LEN_W-1:0] SHORT_LEN_RESET = 13'd28;
    localparam logic [LEN_W-1:0] LONG_LEN_RESET  = 13'd88;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHORT_LEN = 1'b0,
        REG_LONG_LEN  = 1'b1
    } ffc_reg_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_SYNC     = 3'd1,
        ST_UNKNOWN_KIND = 3'd2,
        ST_WRONG_SIZE   = 3'd3,
        ST_BAD_LENGTH   = 3'd4,
        ST_CRC_MISMATCH = 3'd5
    } ffc_status_t;

    typedef struct packed {
        logic [LEN_W-1:0] short_len;
        logic [LEN_W-1:0] long_len;
    } ffc_cfg_t;

    // one classified item as it travels from front to back
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             last_byte;
        logic [IDX_W-1:0] idx;
        logic             crc_en;
        logic             body;
    } ffc_item_t;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

// ===== sv/ffc_if.sv =====
// item channels of the frame checker: frame bytes in, results out
interface ffc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ffc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic [2:0]  status;
    logic [7:0]  frame_version;
    logic [7:0]  frame_type;
    logic [15:0] length_field;
    logic [31:0] sequence_number;
    logic [31:0] epoch_seconds;
    logic [31:0] sub_microseconds;

    modport source (output valid, payload_byte, payload_valid, frame_done, status,
                    frame_version, frame_type, length_field, sequence_number,
                    epoch_seconds, sub_microseconds, input ready);
    modport sink   (input valid, payload_byte, payload_valid, frame_done, status,
                    frame_version, frame_type, length_field, sequence_number,
                    epoch_seconds, sub_microseconds, output ready);
endinterface

// ===== sv/ffc_front.sv =====
// front part: accepts frame bytes, numbers them within the frame and classifies them
module ffc_front #(
    parameter int MAX_FRAME_BYTES = 8192
) (
    input  logic                clk,
    input  logic                rst_n,
    ffc_in_if.sink              frame,
    output logic                item_valid,
    input  logic                item_ready,
    output ffc_pkg::ffc_item_t  item
);

    localparam logic [ffc_pkg::IDX_W-1:0] IDX_MAX = ffc_pkg::IDX_W'(MAX_FRAME_BYTES);

    logic [ffc_pkg::IDX_W-1:0] idx_reg;
    logic [ffc_pkg::IDX_W-1:0] idx_next;
    logic                      take;

    assign frame.ready = item_ready;
    assign item_valid  = frame.valid;
    assign take        = frame.valid && item_ready;

    always_comb
    begin
        item.data_byte = frame.data_byte;
        item.last_byte = frame.last_byte;
        item.idx       = idx_reg;
        item.crc_en    = idx_reg >= ffc_pkg::IDX_W'(ffc_pkg::TAIL_BYTES);
        item.body      = (idx_reg >= ffc_pkg::IDX_W'(ffc_pkg::HEADER_BYTES))
                         && (idx_reg < IDX_MAX);
    end

    // byte count saturates at the frame limit and restarts after the marked byte
    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            if (frame.last_byte)
            begin
                idx_next = '0;
            end
            else if (idx_reg < IDX_MAX)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== sv/ffc_queue.sv =====
// short item queue between front and back
module ffc_queue #(
    parameter int  DEPTH  = 2,
    parameter type item_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/ffc_back.sv =====
// back part: header capture, crc, payload pass-through and frame status
module ffc_back #(
    parameter int MAX_FRAME_BYTES = 8192
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ffc_pkg::ffc_cfg_t   cfg,
    input  logic                item_valid,
    output logic                item_ready,
    input  ffc_pkg::ffc_item_t  item,
    ffc_out_if.source           result
);

    localparam int W = ffc_pkg::SUM_W;
    localparam logic [ffc_pkg::IDX_W-1:0] IDX_MAX = ffc_pkg::IDX_W'(MAX_FRAME_BYTES);

    // per-frame state
    logic [31:0] crc_reg,     crc_next;
    logic [31:0] tail_reg,    tail_next;
    logic        sync_reg,    sync_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  type_reg,    type_next;
    logic [15:0] length_reg,  length_next;
    logic [31:0] seq_reg,     seq_next;
    logic [31:0] epoch_reg,   epoch_next;
    logic [31:0] subsec_reg,  subsec_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg;
    logic                  out_pvalid_reg;
    logic                  out_done_reg;
    ffc_pkg::ffc_status_t  out_status_reg;
    logic [7:0]            out_version_reg;
    logic [7:0]            out_type_reg;
    logic [15:0]           out_length_reg;
    logic [31:0]           out_seq_reg;
    logic [31:0]           out_epoch_reg;
    logic [31:0]           out_subsec_reg;

    logic                      take;
    logic                      in_header;
    logic [4:0]                hpos;
    logic                      known;
    logic [ffc_pkg::LEN_W-1:0] plen;
    logic [W-1:0]              win_end;
    logic [W-1:0]              full_len;
    logic [ffc_pkg::IDX_W-1:0] n;
    logic                      pay_valid;
    ffc_pkg::ffc_status_t      status_next;

    assign item_ready = !out_valid_reg || result.ready;
    assign take       = item_valid && item_ready;
    assign in_header  = item.idx < ffc_pkg::IDX_W'(ffc_pkg::HEADER_BYTES);
    assign hpos       = item.idx[4:0];

    // header capture, one byte lane per position
    always_comb
    begin
        sync_next    = sync_reg;
        version_next = version_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        seq_next     = seq_reg;
        epoch_next   = epoch_reg;
        subsec_next  = subsec_reg;
        if (in_header)
        begin
            case (hpos)
                5'd0:    sync_next = item.data_byte == ffc_pkg::SYNC_FIRST;
                5'd1:    sync_next = sync_reg && (item.data_byte == ffc_pkg::SYNC_SECOND);
                5'd2:    version_next = item.data_byte;
                5'd3:    type_next = item.data_byte;
                5'd4:    length_next[7:0] = item.data_byte;
                5'd5:    length_next[15:8] = item.data_byte;
                5'd6:    seq_next[7:0] = item.data_byte;
                5'd7:    seq_next[15:8] = item.data_byte;
                5'd8:    seq_next[23:16] = item.data_byte;
                5'd9:    seq_next[31:24] = item.data_byte;
                5'd10:   epoch_next[7:0] = item.data_byte;
                5'd11:   epoch_next[15:8] = item.data_byte;
                5'd12:   epoch_next[23:16] = item.data_byte;
                5'd13:   epoch_next[31:24] = item.data_byte;
                5'd14:   subsec_next[7:0] = item.data_byte;
                5'd15:   subsec_next[15:8] = item.data_byte;
                5'd16:   subsec_next[23:16] = item.data_byte;
                5'd17:   subsec_next[31:24] = item.data_byte;
                default: sync_next = sync_reg;
            endcase
        end
    end

    // crc runs four bytes behind the input through the tail line
    assign crc_next  = item.crc_en ? ffc_pkg::crc_byte(crc_reg, tail_reg[7:0]) : crc_reg;
    assign tail_next = {item.data_byte, tail_reg[31:8]};

    always_comb
    begin
        known = ((version_next == ffc_pkg::KIND_SHORT) && (type_next == ffc_pkg::KIND_SHORT))
                || ((version_next == ffc_pkg::KIND_LONG) && (type_next == ffc_pkg::KIND_LONG));
        plen      = (version_next == ffc_pkg::KIND_SHORT) ? cfg.short_len : cfg.long_len;
        win_end   = W'(ffc_pkg::HEADER_BYTES) + W'(plen);
        full_len  = win_end + W'(ffc_pkg::TAIL_BYTES);
        n         = (item.idx < IDX_MAX) ? item.idx + 1'b1 : item.idx;
        pay_valid = item.body && sync_next && known && (W'(item.idx) < win_end);

        if (!sync_next || (W'(n) < W'(ffc_pkg::HEADER_BYTES + ffc_pkg::TAIL_BYTES)))
        begin
            status_next = ffc_pkg::ST_BAD_SYNC;
        end
        else if (!known)
        begin
            status_next = ffc_pkg::ST_UNKNOWN_KIND;
        end
        else if ((n >= IDX_MAX) || (W'(n) != full_len))
        begin
            status_next = ffc_pkg::ST_WRONG_SIZE;
        end
        else if (length_next != 16'(plen))
        begin
            status_next = ffc_pkg::ST_BAD_LENGTH;
        end
        else if (~crc_next != tail_next)
        begin
            status_next = ffc_pkg::ST_CRC_MISMATCH;
        end
        else
        begin
            status_next = ffc_pkg::ST_OK;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            crc_reg       <= ffc_pkg::CRC_INIT;
            tail_reg      <= '0;
            sync_reg      <= 1'b1;
            version_reg   <= '0;
            type_reg      <= '0;
            length_reg    <= '0;
            seq_reg       <= '0;
            epoch_reg     <= '0;
            subsec_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                if (item.last_byte)
                begin
                    crc_reg     <= ffc_pkg::CRC_INIT;
                    tail_reg    <= '0;
                    sync_reg    <= 1'b1;
                    version_reg <= '0;
                    type_reg    <= '0;
                    length_reg  <= '0;
                    seq_reg     <= '0;
                    epoch_reg   <= '0;
                    subsec_reg  <= '0;
                end
                else
                begin
                    crc_reg     <= crc_next;
                    tail_reg    <= tail_next;
                    sync_reg    <= sync_next;
                    version_reg <= version_next;
                    type_reg    <= type_next;
                    length_reg  <= length_next;
                    seq_reg     <= seq_next;
                    epoch_reg   <= epoch_next;
                    subsec_reg  <= subsec_next;
                end
            end
        end
    end

    // result payload, fields zero unless the item closes a frame
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_byte_reg    <= pay_valid ? item.data_byte : 8'd0;
            out_pvalid_reg  <= pay_valid;
            out_done_reg    <= item.last_byte;
            out_status_reg  <= item.last_byte ? status_next : ffc_pkg::ST_OK;
            out_version_reg <= item.last_byte ? version_next : 8'd0;
            out_type_reg    <= item.last_byte ? type_next : 8'd0;
            out_length_reg  <= item.last_byte ? length_next : 16'd0;
            out_seq_reg     <= item.last_byte ? seq_next : 32'd0;
            out_epoch_reg   <= item.last_byte ? epoch_next : 32'd0;
            out_subsec_reg  <= item.last_byte ? subsec_next : 32'd0;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.payload_byte     = out_byte_reg;
    assign result.payload_valid    = out_pvalid_reg;
    assign result.frame_done       = out_done_reg;
    assign result.status           = out_status_reg;
    assign result.frame_version    = out_version_reg;
    assign result.frame_type       = out_type_reg;
    assign result.length_field     = out_length_reg;
    assign result.sequence_number  = out_seq_reg;
    assign result.epoch_seconds    = out_epoch_reg;
    assign result.sub_microseconds = out_subsec_reg;

    a_frame_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.last_byte |=> crc_reg == ffc_pkg::CRC_INIT && tail_reg == 32'd0
                                   && sync_reg && length_reg == 16'd0 && seq_reg == 32'd0)
        else $error("per-frame state not cleared after the marked item");

    a_fields_zero_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.frame_done |-> result.status == ffc_pkg::ST_OK
                                               && result.length_field == 16'd0
                                               && result.sequence_number == 32'd0)
        else $error("header fields reported on an item that does not close a frame");

    a_payload_byte_masked: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.payload_valid |-> result.payload_byte == 8'd0)
        else $error("payload byte not masked outside the payload region");

endmodule

// ===== sv/feature_frame_checker_crc32.sv =====
// top level of the length-checked frame checker with crc-32
//
// frame: one frame byte per item, last_byte set on the final byte of a frame.
// result: one item for every frame byte. payload_valid and payload_byte pass
// bytes of the payload region through; the item for the marked byte has
// frame_done set and carries the status and the captured header fields.
// cfg_we/cfg_index/cfg_data write short_payload_length (index 0) and
// long_payload_length (index 1); the user must write them only while no frame item
// is in flight, the block does not enforce it. throughput: one item per cycle
// while result is not stalled; the crc step for a byte is combinational xor logic,
// and the front, a two-entry queue and the back output register each hand on one
// item per cycle. an accepted item is registered in the queue, then in the back
// output register. reset clears the byte count and all per-frame state and sets the
// payload lengths to 28 and 88. when result is stalled the output register holds
// its item, the queue fills, and frame.ready drops once two items wait.
module feature_frame_checker_crc32 #(
    parameter int MAX_FRAME_BYTES = 8192,
    parameter int QUEUE_DEPTH     = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ffc_in_if.sink                        frame,
    ffc_out_if.source                     result,
    input  logic                          cfg_we,
    input  logic [ffc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffc_pkg::LEN_W-1:0]     cfg_data
);

    ffc_pkg::ffc_cfg_t   cfg_reg;
    ffc_pkg::ffc_cfg_t   cfg_next;
    ffc_pkg::ffc_item_t  front_item;
    ffc_pkg::ffc_item_t  back_item;
    logic                front_valid;
    logic                front_ready;
    logic                back_valid;
    logic                back_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (ffc_pkg::ffc_reg_t'(cfg_index))
                ffc_pkg::REG_SHORT_LEN: cfg_next.short_len = cfg_data;
                ffc_pkg::REG_LONG_LEN:  cfg_next.long_len = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_len <= ffc_pkg::SHORT_LEN_RESET;
            cfg_reg.long_len  <= ffc_pkg::LONG_LEN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ffc_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    ffc_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .item_t (ffc_pkg::ffc_item_t)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    ffc_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .result     (result)
    );

endmodule
